// ===== sv/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int RunMax  = 4;  // bytes in one gathered run
    localparam int HeldMax = 3;  // bytes held while a sequence is open

    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_VAL  = 8'hF0;
    localparam logic [25:0] SUPP_BASE  = 26'h001_0000;
    localparam logic [15:0] SURR_HIGH  = 16'hD800;
    localparam logic [15:0] SURR_LOW   = 16'hDC00;

    typedef logic [7:0]  text_byte_t;
    typedef logic [15:0] code_unit_t;

    // A complete run of bytes handed from the gather stage to the decoder
    typedef struct packed {
        logic [RunMax-1:0][7:0] bytes;  // bytes[0] is the first byte
        logic [2:0]             n;      // valid bytes, 1..4
        logic                   last;   // run closes the text
    } run_t;

    // Decoded code units of one run
    typedef struct packed {
        logic [RunMax-1:0][15:0] units;
        logic [2:0]              count;  // 1..4
    } units_t;

    // Number of following bytes a lead byte calls for; zero if not a lead
    function automatic logic [1:0] lead_need(input text_byte_t c);
        logic [1:0] need;
        need = 2'd0;
        if ((c & LEAD2_MASK) == LEAD2_VAL)
        begin
            need = 2'd1;
        end
        else if ((c & LEAD3_MASK) == LEAD3_VAL)
        begin
            need = 2'd2;
        end
        else if ((c & LEAD4_MASK) == LEAD4_VAL)
        begin
            need = 2'd3;
        end
        return need;
    endfunction

endpackage

// ===== sv/u2u_gather.sv =====
// ----------------------------------------------------------------------------
// u2u_gather
// Holds an open multi-byte sequence and registers each complete run.
// ----------------------------------------------------------------------------
module u2u_gather
    import u2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  text_byte_t text_byte,
    input  logic       ends_text,
    input  logic       in_fire,
    input  logic       run_take,
    output run_t       run,
    output logic       run_valid
);

    text_byte_t held_reg [HeldMax];
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [1:0] need_reg, need_next;
    run_t       run_reg, run_next;
    logic       run_valid_reg, run_valid_next;
    logic [1:0] c_need;
    logic       emit;

    assign c_need = lead_need(text_byte);

    // Emit a run when nothing starts or the open sequence is complete or cut short
    always_comb
    begin
        if (held_cnt_reg == 2'd0)
        begin
            emit = (c_need == 2'd0) || ends_text;
        end
        else
        begin
            emit = ends_text || (held_cnt_reg >= need_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < HeldMax; i++)
        begin
            run_next.bytes[i] = (2'(i) < held_cnt_reg) ? held_reg[i] : text_byte;
        end
        run_next.bytes[RunMax-1] = text_byte;
        run_next.n               = {1'b0, held_cnt_reg} + 3'd1;
        run_next.last            = ends_text;
    end

    always_comb
    begin
        held_cnt_next  = held_cnt_reg;
        need_next      = need_reg;
        run_valid_next = run_valid_reg;
        if (run_take)
        begin
            run_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            if (emit)
            begin
                held_cnt_next  = 2'd0;
                need_next      = 2'd0;
                run_valid_next = 1'b1;
            end
            else
            begin
                held_cnt_next = held_cnt_reg + 2'd1;
                if (held_cnt_reg == 2'd0)
                begin
                    need_next = c_need;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg  <= 2'd0;
            need_reg      <= 2'd0;
            run_valid_reg <= 1'b0;
        end
        else
        begin
            held_cnt_reg  <= held_cnt_next;
            need_reg      <= need_next;
            run_valid_reg <= run_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            run_reg <= run_next;
        end
        if (in_fire && !emit)
        begin
            held_reg[held_cnt_reg] <= text_byte;
        end
    end

    assign run       = run_reg;
    assign run_valid = run_valid_reg;

    a_held_within_need: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= need_reg)
        else $error("held byte count exceeds the lead's need");

    a_open_iff_need: assert property (@(posedge clk) disable iff (!rst_n)
        (held_cnt_reg == 2'd0) == (need_reg == 2'd0))
        else $error("open sequence and need count disagree");

    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg && !run_take |=> run_valid_reg && $stable(run_reg))
        else $error("pending run lost or changed");

endmodule

// ===== sv/u2u_decode.sv =====
// ----------------------------------------------------------------------------
// u2u_decode
// Decodes one run of up to four bytes into up to four UTF-16 code units.
// ----------------------------------------------------------------------------
module u2u_decode
    import u2u_pkg::*;
(
    input  run_t   run,
    output units_t dec
);

    logic [8*(2*RunMax-1)-1:0] ext;
    code_unit_t                pos_u0  [RunMax];
    code_unit_t                pos_u1  [RunMax];
    logic [2:0]                pos_len [RunMax];
    logic                      pos_two [RunMax];

    assign ext = {{(8*(RunMax-1)){1'b0}}, run.bytes};

    // Decode a sequence starting at every byte position in parallel
    always_comb
    begin
        for (int p = 0; p < RunMax; p++)
        begin
            logic [7:0]  b0, b1, b2, b3;
            logic [1:0]  need;
            logic        full;
            logic [20:0] cp;
            logic [25:0] off;
            b0   = ext[8*p +: 8];
            b1   = ext[8*(p+1) +: 8];
            b2   = ext[8*(p+2) +: 8];
            b3   = ext[8*(p+3) +: 8];
            need = lead_need(b0);
            full = (need != 2'd0) && ((3'(p) + {1'b0, need}) < run.n);
            cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            off  = {5'd0, cp} - SUPP_BASE;
            pos_two[p] = 1'b0;
            pos_u1[p]  = SURR_LOW + {6'd0, off[9:0]};
            if (!full)
            begin
                pos_u0[p]  = {8'd0, b0};
                pos_len[p] = 3'd1;
            end
            else
            begin
                case (need)
                    2'd1:
                    begin
                        pos_u0[p] = {5'd0, b0[4:0], b1[5:0]};
                    end
                    2'd2:
                    begin
                        pos_u0[p] = {b0[3:0], b1[5:0], b2[5:0]};
                    end
                    default:
                    begin
                        pos_u0[p]  = SURR_HIGH + off[25:10];
                        pos_two[p] = 1'b1;
                    end
                endcase
                pos_len[p] = {1'b0, need} + 3'd1;
            end
        end
    end

    // Walk the run from the first byte, appending units in order
    always_comb
    begin
        logic [2:0] pos;
        logic [2:0] k;
        logic [1:0] sel;
        pos       = 3'd0;
        k         = 3'd0;
        sel       = 2'd0;
        dec.units = '0;
        for (int s = 0; s < RunMax; s++)
        begin
            if ((pos < run.n) && (k < 3'(RunMax)))
            begin
                sel                = pos[1:0];
                dec.units[k[1:0]]  = pos_u0[sel];
                k                  = k + 3'd1;
                if (pos_two[sel] && (k < 3'(RunMax)))
                begin
                    dec.units[k[1:0]] = pos_u1[sel];
                    k                 = k + 3'd1;
                end
                pos = pos + pos_len[sel];
            end
        end
        dec.count = k;
    end

endmodule

// ===== sv/utf8_to_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Streaming UTF-8 to UTF-16 transcoder with a registered unit buffer.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle on the slave stream (tlast marks
// the final byte of a text) and gives UTF-16 code units on the master stream.
// A lead byte and its following bytes are held in the gather stage until the
// sequence is complete; the complete run is registered, decoded in one pass of
// logic and loaded into a four-entry unit buffer that drains one unit per
// cycle while the master is ready. A byte that only extends an open sequence
// is held and gives nothing; a run that gives k units sends k units on the
// master stream (one for most characters, two for a surrogate pair, up to
// three when a text ends inside a sequence), and the slave side stalls only
// while the run register is full and the unit buffer has not yet sent its
// final unit. Master tlast flags the final unit caused by one input byte;
// tuser flags the final unit of the whole text. Following bytes are not
// checked as continuation bytes; stray and truncated bytes pass through as
// raw units.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // ends_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast,   // last_of_run
    output logic [0:0]  m_axis_tuser    // [0] text_done
);

    run_t       run;
    logic       run_valid;
    logic       run_take;
    logic       in_fire;
    units_t     dec;

    code_unit_t ubuf_reg [RunMax];
    logic [2:0] ucnt_reg, ucnt_next;
    logic [1:0] uidx_reg, uidx_next;
    logic       uvalid_reg, uvalid_next;
    logic       ulast_reg, ulast_next;
    logic       out_final;
    logic       buf_free;

    // Take a byte whenever the run register is empty or being emptied
    assign s_axis_tready = !run_valid || run_take;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    u2u_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (s_axis_tdata),
        .ends_text (s_axis_tlast),
        .in_fire   (in_fire),
        .run_take  (run_take),
        .run       (run),
        .run_valid (run_valid)
    );

    u2u_decode u_decode (
        .run (run),
        .dec (dec)
    );

    // Buffer frees up on the transfer of its final unit
    assign out_final = ({1'b0, uidx_reg} + 3'd1) == ucnt_reg;
    assign buf_free  = !uvalid_reg || (m_axis_tready && out_final);
    assign run_take  = run_valid && buf_free;

    always_comb
    begin
        ucnt_next   = ucnt_reg;
        uidx_next   = uidx_reg;
        uvalid_next = uvalid_reg;
        ulast_next  = ulast_reg;
        if (run_take)
        begin
            ucnt_next   = dec.count;
            uidx_next   = 2'd0;
            uvalid_next = 1'b1;
            ulast_next  = run.last;
        end
        else if (uvalid_reg && m_axis_tready)
        begin
            // advance to the next unit, or drop the buffer after its final one
            uidx_next = uidx_reg + 2'd1;
            if (out_final)
            begin
                uvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucnt_reg   <= 3'd1;
            uidx_reg   <= 2'd0;
            uvalid_reg <= 1'b0;
            ulast_reg  <= 1'b0;
        end
        else
        begin
            ucnt_reg   <= ucnt_next;
            uidx_reg   <= uidx_next;
            uvalid_reg <= uvalid_next;
            ulast_reg  <= ulast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_take)
        begin
            for (int i = 0; i < RunMax; i++)
            begin
                ubuf_reg[i] <= dec.units[i];
            end
        end
    end

    assign m_axis_tvalid   = uvalid_reg;
    assign m_axis_tdata    = ubuf_reg[uidx_reg];
    assign m_axis_tlast    = out_final;
    assign m_axis_tuser[0] = out_final && ulast_reg;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        uvalid_reg |-> (ucnt_reg != 3'd0) && (ucnt_reg <= 3'(RunMax))
                       && ({1'b0, uidx_reg} < ucnt_reg))
        else $error("unit index outside the loaded count");

    a_done_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tuser[0] |-> m_axis_tlast)
        else $error("text end flagged on a unit that is not final");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        uvalid_reg && !m_axis_tready |-> !run_take)
        else $error("unit buffer reloaded while stalled");

endmodule

// ===== test/tb_utf8_to_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder_unit
// Self-checking bench for the streaming UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
// The bench feeds bytes on the slave stream and checks each code unit on the
// master stream against a queue of expected units. Each unit is checked for
// its value, its tlast and its tuser. The expected units come from a
// behavioural decoder inside the bench. That decoder keeps its own copy of the
// open sequence and is updated on every accepted byte.
// A short directed table goes first: extreme bytes, every sequence length,
// surrogate wrap-around, and texts that end inside a sequence. The unit is
// typed into the table only where it is obvious. After the table come random
// texts, which are mostly well-formed with random content, with noise and
// truncated sequences mixed in. The run has three idling phases.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_unit
    import u2u_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One expected code unit with its two flags
    typedef struct packed {
        code_unit_t unit;
        logic       run_end;   // final unit caused by one byte
        logic       text_end;  // final unit of the text
    } unit_exp_t;

    // One row of the directed table; typed rows carry their own single unit
    typedef struct packed {
        text_byte_t text_byte;
        logic       ends_text;
        logic       typed;
        code_unit_t typed_unit;
    } stim_row_t;

    localparam int NumDirected = 27;
    localparam int RandomBytesPerPhase = 25;
    localparam int TailCycles = 20;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tlast;   // ends_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] code_unit
    logic        m_axis_tlast;   // last_of_run
    logic [0:0]  m_axis_tuser;   // [0] text_done

    // Decoder state: the open lead and its following bytes so far
    text_byte_t  open_bytes [HeldMax];
    int unsigned open_count;
    int unsigned open_need;

    unit_exp_t   pending_units [$];
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Extremes first (typed), then each sequence length, the wrap-around of
    // the surrogate arithmetic, and texts that end inside a sequence
    stim_row_t directed_rows [NumDirected] = '{
        '{8'h00, 1'b1, 1'b1, 16'h0000},  // zero byte ends a text
        '{8'h7F, 1'b0, 1'b1, 16'h007F},  // top of the single-byte range
        '{8'h80, 1'b0, 1'b1, 16'h0080},  // stray following byte goes raw
        '{8'hFF, 1'b0, 1'b1, 16'h00FF},  // not a lead, goes raw
        '{8'hC3, 1'b1, 1'b1, 16'h00C3},  // lead as the final byte
        '{8'hC3, 1'b0, 1'b0, 16'h0000},  // two-byte sequence
        '{8'hA9, 1'b0, 1'b0, 16'h0000},
        '{8'hE2, 1'b0, 1'b0, 16'h0000},  // three-byte sequence
        '{8'h82, 1'b0, 1'b0, 16'h0000},
        '{8'hAC, 1'b0, 1'b0, 16'h0000},
        '{8'hF0, 1'b0, 1'b0, 16'h0000},  // four-byte sequence, surrogate pair
        '{8'h9F, 1'b0, 1'b0, 16'h0000},
        '{8'h98, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'hF7, 1'b0, 1'b0, 16'h0000},  // largest four-byte value
        '{8'hBF, 1'b0, 1'b0, 16'h0000},
        '{8'hBF, 1'b0, 1'b0, 16'h0000},
        '{8'hBF, 1'b1, 1'b0, 16'h0000},
        '{8'hF0, 1'b0, 1'b0, 16'h0000},  // value below 0x10000 wraps round
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b0, 16'h0000},
        '{8'hE0, 1'b0, 1'b0, 16'h0000},  // text ends inside a sequence
        '{8'h00, 1'b1, 1'b0, 16'h0000},
        '{8'hF0, 1'b0, 1'b0, 16'h0000},  // truncated lead hides a full two-byte sequence
        '{8'hC3, 1'b0, 1'b0, 16'h0000},
        '{8'hA9, 1'b1, 1'b0, 16'h0000}
    };

    utf8_to_utf16_transcoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Number of following bytes that a lead calls for; zero for any other byte
    function automatic int unsigned lead_tail_len(input text_byte_t c);
        casez (c)
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    // Advance the decoder by one accepted byte and queue the units it
    // completes; drop the units when the caller has typed them in already
    function automatic void decode_byte(input text_byte_t c, input logic fin,
                                        input bit record);
        text_byte_t  run [RunMax];
        code_unit_t  units [$];
        int unsigned n;
        int unsigned i;
        int unsigned tail;
        logic [31:0] v;
        unit_exp_t   e;
        if (open_count == 0)
        begin
            tail = lead_tail_len(c);
            if (tail != 0 && !fin)
            begin
                open_bytes[0] = c;
                open_count = 1;
                open_need = tail;
                return;
            end
            run[0] = c;
            n = 1;
        end
        else
        begin
            for (i = 0; i < open_count; i++)
            begin
                run[i] = open_bytes[i];
            end
            run[open_count] = c;
            n = open_count + 1;
            if (!fin && n < open_need + 1)
            begin
                open_bytes[open_count] = c;
                open_count = n;
                return;
            end
        end
        open_count = 0;
        open_need = 0;

        // Decode again from the first byte; the end of the run is the bound,
        // so a lead short of its following bytes goes out raw
        i = 0;
        while (i < n && units.size() < RunMax)
        begin
            tail = lead_tail_len(run[i]);
            if (tail == 0 || i + tail >= n)
            begin
                units.push_back({8'h00, run[i]});
                i += 1;
            end
            else if (tail == 1)
            begin
                units.push_back({5'b0, run[i][4:0], run[i+1][5:0]});
                i += 2;
            end
            else if (tail == 2)
            begin
                units.push_back({run[i][3:0], run[i+1][5:0], run[i+2][5:0]});
                i += 3;
            end
            else
            begin
                v = {11'b0, run[i][2:0], run[i+1][5:0], run[i+2][5:0], run[i+3][5:0]};
                v = v - 32'(SUPP_BASE);
                units.push_back(16'(32'(SURR_HIGH) + (v >> 10)));
                if (units.size() < RunMax)
                begin
                    units.push_back(16'(32'(SURR_LOW) + 32'(v[9:0])));
                end
                i += 4;
            end
        end

        if (record)
        begin
            foreach (units[j])
            begin
                e.unit = units[j];
                e.run_end = (j == units.size() - 1);
                e.text_end = e.run_end && fin;
                pending_units.push_back(e);
            end
        end
    endfunction

    // Offer one byte, hold it until the transfer, then idle at random.
    // tvalid stays high for the next byte unless a gap is taken.
    task automatic send_byte(input text_byte_t b, input logic fin, input bit record);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        decode_byte(b, fin, record);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Build one random text of a few characters and send it. Most characters
    // are well-formed; some are noise or carry raw bytes after a lead, and
    // some texts are cut short inside a sequence.
    task automatic send_random_text(output int unsigned sent);
        text_byte_t  bytes [$];
        int unsigned n_chars;
        int unsigned tail;
        int unsigned cut;
        bit          wild;
        n_chars = $urandom_range(5, 1);
        for (int unsigned ch = 0; ch < n_chars; ch++)
        begin
            tail = 0;
            wild = 1'b0;
            case ($urandom_range(9))
                0, 1, 2: bytes.push_back(8'($urandom_range(127)));
                3, 4:
                begin
                    bytes.push_back({3'b110, 5'($urandom)});
                    tail = 1;
                end
                5, 6:
                begin
                    bytes.push_back({4'b1110, 4'($urandom)});
                    tail = 2;
                end
                7:
                begin
                    bytes.push_back({5'b11110, 3'($urandom)});
                    tail = 3;
                end
                8: bytes.push_back(8'($urandom));
                default:
                begin
                    tail = $urandom_range(3, 1);
                    wild = 1'b1;
                    case (tail)
                        1:       bytes.push_back({3'b110, 5'($urandom)});
                        2:       bytes.push_back({4'b1110, 4'($urandom)});
                        default: bytes.push_back({5'b11110, 3'($urandom)});
                    endcase
                end
            endcase
            for (int unsigned t = 0; t < tail; t++)
            begin
                bytes.push_back(wild ? 8'($urandom) : {2'b10, 6'($urandom)});
            end
        end
        if (bytes.size() > 1 && $urandom_range(3) == 0)
        begin
            cut = $urandom_range(bytes.size(), 1);
            while (bytes.size() > cut)
            begin
                void'(bytes.pop_back());
            end
        end
        foreach (bytes[i])
        begin
            send_byte(bytes[i], i == bytes.size() - 1, 1'b1);
        end
        sent = bytes.size();
    endtask

    task automatic send_random_phase();
        int unsigned total;
        int unsigned sent;
        total = 0;
        while (total < RandomBytesPerPhase)
        begin
            send_random_text(sent);
            total += sent;
        end
    endtask

    // Lower tvalid and hold the sender until every expected unit is in
    task automatic drain_units();
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Master side: check each transfer against the oldest expectation, then
    // pick tready for the next cycle
    always @(posedge clk)
    begin : unit_sink
        unit_exp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_units.size() == 0)
            begin
                $error("unexpected code_unit 0x%04h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_units.pop_front();
                if (m_axis_tdata !== want.unit)
                begin
                    $error("code_unit: expected 0x%04h, got 0x%04h", want.unit, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.run_end)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.run_end, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.text_end)
                begin
                    $error("text_done: expected %0b, got %0b", want.text_end, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        fail_count     = 0;
        open_count     = 0;
        open_need      = 0;
        send_idle_pct  = 10;
        recv_stall_pct = 52;
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= 8'h00;
        s_axis_tlast   <= 1'b0;
        m_axis_tready  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: light sender gaps, heavy receiver stalls
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].typed)
            begin
                pending_units.push_back('{directed_rows[r].typed_unit, 1'b1,
                                          directed_rows[r].ends_text});
            end
            send_byte(directed_rows[r].text_byte, directed_rows[r].ends_text,
                      !directed_rows[r].typed);
        end
        send_random_phase();
        drain_units();

        // Phase two: the other way round
        send_idle_pct  = 52;
        recv_stall_pct = 10;
        send_random_phase();
        drain_units();

        // Phase three: full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_phase();
        drain_units();

        // Give any stray unit time to show up
        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #500_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/u2u_pkg.sv
sv/u2u_gather.sv
sv/u2u_decode.sv
sv/utf8_to_utf16_transcoder_unit.sv
test/tb_utf8_to_utf16_transcoder_unit.sv
